// ----- src/ahdt_pkg.sv -----
`default_nettype none

package ahdt_pkg;

	// Action codes carried in the input tuser field.
	localparam logic [1:0] ACT_EVAL  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_RESET = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_COMP      = 3'd0;
	localparam logic [2:0] REG_MIN_HEAT  = 3'd1;
	localparam logic [2:0] REG_BASE_WAIT = 3'd2;
	localparam logic [2:0] REG_BAND_WAIT = 3'd3;
	localparam logic [2:0] REG_MAX_WAIT  = 3'd4;

	localparam int CFG_DATA_W = 7;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 16;

	localparam logic [5:0] SEC_LAST   = 6'd59;
	localparam logic [6:0] SP_CAP_DEG = 7'd60;
	localparam logic [6:0] SP_LOW_DEG = 7'd20;
	localparam logic [7:0] SP_CAP_HALF = 8'd120;
	localparam logic [6:0] OFF_MAX    = 7'd127;
	localparam logic [6:0] WAIT_RESET = 7'd6;

	localparam logic [4:0] COMP_RESET      = 5'd3;
	localparam logic [3:0] MIN_HEAT_RESET  = 4'd3;
	localparam logic [5:0] BASE_WAIT_RESET = 6'd6;
	localparam logic [5:0] BAND_WAIT_RESET = 6'd12;
	localparam logic [6:0] MAX_WAIT_RESET  = 7'd103;

	typedef struct packed {
		logic [4:0] comp_half_degrees;
		logic [3:0] min_heat_minutes;
		logic [5:0] base_wait_minutes;
		logic [5:0] band_wait_minutes;
		logic [6:0] max_wait_minutes;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        action;
		logic signed [8:0] temp_half;
		logic [6:0]        set_degrees;
		logic              running;
		logic              heat_enable;
		logic              over_temp;
		logic              fault_latched;
		logic              second_tick;
		logic              heat_delay_done;
		logic              fan_delay_done;
	} item_t;

	typedef struct packed {
		logic       heat_on;
		logic       fall_pending;
		logic       start_delay_pending;
		logic       fan_hold;
		logic       sec_pending;
		logic [5:0] seconds_count;
		logic [6:0] off_minutes;
		logic [6:0] wait_minutes;
		logic       heater_level;
		logic       fan_level;
	} state_t;

endpackage

`default_nettype wire

// ----- src/ahdt_step.sv -----
`default_nettype none

// Next-state function of the thermostat for one item.
module ahdt_step import ahdt_pkg::*; (
	input  wire state_t cur,
	input  wire cfg_t   cfg,
	input  wire item_t  item,
	output state_t      nxt
);

	// One second tick: advance the seconds and, on a minute boundary, run the wait/heat cycle.
	function automatic state_t count_time(state_t s, cfg_t c);
		logic [7:0] on_sum;
		logic [7:0] grow;
		begin
			on_sum = 8'd0;
			grow = 8'd0;
			if (s.sec_pending) begin
				s.sec_pending = 1'b0;
				if (s.seconds_count == SEC_LAST) begin
					s.seconds_count = 6'd0;
					if (s.off_minutes != OFF_MAX) begin
						s.off_minutes = s.off_minutes + 7'd1;
					end
					on_sum = {1'b0, s.off_minutes} + {4'd0, c.min_heat_minutes};
					if (on_sum >= {1'b0, s.wait_minutes}) begin
						s.fall_pending = 1'b1;
						s.start_delay_pending = 1'b1;
						s.heat_on = 1'b1;
						if (s.off_minutes >= s.wait_minutes) begin
							grow = {1'b0, s.wait_minutes} + {4'd0, c.min_heat_minutes};
							if (grow >= {1'b0, c.max_wait_minutes}) begin
								s.wait_minutes = c.max_wait_minutes;
							end else begin
								s.wait_minutes = grow[6:0];
							end
							s.heat_on = 1'b0;
							s.fall_pending = 1'b0;
							s.off_minutes = 7'd0;
							s.seconds_count = 6'd0;
						end
					end
				end else begin
					s.seconds_count = s.seconds_count + 6'd1;
				end
			end
			return s;
		end
	endfunction

	always_comb begin
		state_t            s;
		logic [7:0]        sp;
		logic signed [10:0] sp_x;
		logic signed [10:0] t_x;
		logic              below;
		logic              above;
		logic              skip;
		logic [7:0]        on_sum;
		logic [7:0]        floor_sum;

		s = cur;
		sp = 8'd0;
		skip = 1'b0;
		on_sum = 8'd0;
		floor_sum = 8'd0;

		if (item.second_tick) begin
			s.sec_pending = 1'b1;
		end
		if (item.heat_delay_done) begin
			s.start_delay_pending = 1'b0;
		end
		if (item.fan_delay_done) begin
			s.fan_hold = 1'b0;
		end

		// Effective setpoint in half degrees, capped at high setpoints, with low-setpoint compensation.
		if (item.set_degrees >= SP_CAP_DEG) begin
			sp = SP_CAP_HALF;
		end else if (item.set_degrees <= SP_LOW_DEG) begin
			sp = {item.set_degrees, 1'b0} + {3'd0, cfg.comp_half_degrees};
		end else begin
			sp = {item.set_degrees, 1'b0};
		end
		sp_x = $signed({3'd0, sp});
		t_x = 11'(item.temp_half);
		below = sp_x >= t_x + 11'sd2;
		above = sp_x <= t_x - 11'sd2;

		case (item.action)
			ACT_START: begin
				s.start_delay_pending = 1'b1;
				s.heat_on = 1'b1;
				s.fall_pending = 1'b1;
				s.wait_minutes = {3'd0, cfg.min_heat_minutes};
				s.off_minutes = 7'd0;
				s.seconds_count = 6'd0;
			end
			ACT_RESET: begin
				s.heat_on = 1'b0;
				s.fall_pending = 1'b0;
				s.off_minutes = 7'd0;
				s.seconds_count = 6'd0;
				s.wait_minutes = {1'b0, cfg.base_wait_minutes};
			end
			ACT_EVAL: begin
				if (item.fault_latched && item.running) begin
					s.fan_level = 1'b0;
					s.fan_hold = 1'b0;
					s.start_delay_pending = 1'b0;
				end else if (!item.running || !item.heat_enable || item.over_temp) begin
					s.heater_level = 1'b0;
					s.heat_on = 1'b0;
					s.start_delay_pending = 1'b0;
					if (!s.fan_hold) begin
						s.fan_level = 1'b0;
					end
				end else begin
					if (below) begin
						if (!s.heat_on) begin
							s.start_delay_pending = 1'b1;
							s.heat_on = 1'b1;
							s.wait_minutes = {1'b0, cfg.base_wait_minutes};
						end
						if (s.fall_pending) begin
							s.fall_pending = 1'b0;
							on_sum = {1'b0, s.off_minutes} + {4'd0, cfg.min_heat_minutes};
							if (on_sum > {1'b0, s.wait_minutes}) begin
								// Shrink by the minimum heat time, never below the base wait.
								floor_sum = {2'd0, cfg.base_wait_minutes}
									+ {4'd0, cfg.min_heat_minutes};
								if ({1'b0, s.wait_minutes} <= floor_sum) begin
									s.wait_minutes = {1'b0, cfg.base_wait_minutes};
								end else begin
									s.wait_minutes = s.wait_minutes
										- {3'd0, cfg.min_heat_minutes};
								end
							end
						end
						s.off_minutes = 7'd0;
						s.seconds_count = 6'd0;
					end else begin
						if (above) begin
							if (s.heat_on && !s.fall_pending) begin
								s.heat_on = 1'b0;
								if (s.wait_minutes <= {3'd0, cfg.min_heat_minutes}) begin
									s.wait_minutes = {1'b0, cfg.base_wait_minutes};
								end
							end
						end else if (s.heat_on) begin
							skip = !s.fall_pending;
						end else begin
							s.wait_minutes = {1'b0, cfg.band_wait_minutes};
						end
						if (!skip) begin
							s = count_time(s, cfg);
						end
					end

					if (s.heat_on) begin
						if (!s.start_delay_pending) begin
							s.heater_level = 1'b1;
						end
						s.fan_level = 1'b1;
						s.fan_hold = 1'b1;
					end else begin
						s.heater_level = 1'b0;
						if (!s.fan_hold) begin
							s.fan_level = 1'b0;
						end
						s.start_delay_pending = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase

		nxt = s;
	end

endmodule

`default_nettype wire

// ----- src/adaptive_heater_duty_thermostat_core.sv -----
`default_nettype none

// Heater thermostat with a one-degree band around the setpoint, in half-degree units.
// Every input beat is one control evaluation or command and yields exactly one output
// beat carrying the heater and fan levels, the heat demand flag and the current
// adaptive wait target. The block accepts one beat per clock cycle while the sink keeps
// up: a beat is captured in an input register, its whole state update is one
// combinational pass into the state and output registers, and its result is presented
// from the output register. The throughput is bounded only by the sink: the output
// register can hold a finished result while the next beat is already in the input
// register. The user must write the five configuration registers through the cfg port
// only while no beat is in flight; the block itself does not enforce this.
module adaptive_heater_duty_thermostat_core import ahdt_pkg::*; (
	input  wire                    clk,
	input  wire                    arst_n,

	input  wire                    s_tvalid,
	output logic                   s_tready,
	// temp_half[8:0], set_degrees[15:9], running[16], heat_enable[17], over_temp[18],
	// fault_latched[19], second_tick[20], heat_delay_done[21], fan_delay_done[22],
	// zero pad[23]
	input  wire [IN_DATA_W-1:0]    s_tdata,
	// action[1:0]
	input  wire [1:0]              s_tuser,

	output logic                   m_tvalid,
	input  wire                    m_tready,
	// heater_drive[0], fan_drive[1], heat_request[2], wait_target[9:3], zero pad[15:10]
	output logic [OUT_DATA_W-1:0]  m_tdata,

	input  wire                    cfg_we,
	input  wire [2:0]              cfg_index,
	input  wire [CFG_DATA_W-1:0]   cfg_data
);

	item_t  item_in;
	item_t  item_s1;
	logic   valid_s1;
	cfg_t   cfg_q;
	state_t st_q;
	state_t st_nxt;
	logic   out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic   advance;
	logic   fire;

	// Unpack the input beat.
	always_comb begin
		item_in.action          = s_tuser;
		item_in.temp_half       = $signed(s_tdata[8:0]);
		item_in.set_degrees     = s_tdata[15:9];
		item_in.running         = s_tdata[16];
		item_in.heat_enable     = s_tdata[17];
		item_in.over_temp       = s_tdata[18];
		item_in.fault_latched   = s_tdata[19];
		item_in.second_tick     = s_tdata[20];
		item_in.heat_delay_done = s_tdata[21];
		item_in.fan_delay_done  = s_tdata[22];
	end

	// The output register frees up when it is empty or its beat is being taken.
	assign advance  = !out_valid_q || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	// Configuration registers; writes to unused indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.comp_half_degrees <= COMP_RESET;
			cfg_q.min_heat_minutes  <= MIN_HEAT_RESET;
			cfg_q.base_wait_minutes <= BASE_WAIT_RESET;
			cfg_q.band_wait_minutes <= BAND_WAIT_RESET;
			cfg_q.max_wait_minutes  <= MAX_WAIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COMP:      cfg_q.comp_half_degrees <= cfg_data[4:0];
				REG_MIN_HEAT:  cfg_q.min_heat_minutes  <= cfg_data[3:0];
				REG_BASE_WAIT: cfg_q.base_wait_minutes <= cfg_data[5:0];
				REG_BAND_WAIT: cfg_q.band_wait_minutes <= cfg_data[5:0];
				REG_MAX_WAIT:  cfg_q.max_wait_minutes  <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_in;
		end
	end

	ahdt_step u_step (
		.cur  (st_q),
		.cfg  (cfg_q),
		.item (item_s1),
		.nxt  (st_nxt)
	);

	// Controller state is committed together with the result it produces, so the
	// next beat in the input register always sees the up-to-date state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.heat_on             <= 1'b0;
			st_q.fall_pending        <= 1'b0;
			st_q.start_delay_pending <= 1'b0;
			st_q.fan_hold            <= 1'b0;
			st_q.sec_pending         <= 1'b0;
			st_q.seconds_count       <= 6'd0;
			st_q.off_minutes         <= 7'd0;
			st_q.wait_minutes        <= WAIT_RESET;
			st_q.heater_level        <= 1'b0;
			st_q.fan_level           <= 1'b0;
			out_valid_q              <= 1'b0;
		end else begin
			if (fire) begin
				st_q        <= st_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= {6'd0, st_nxt.wait_minutes, st_nxt.heat_on,
				st_nxt.fan_level, st_nxt.heater_level};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// The seconds counter wraps after the last second of a minute.
	a_sec_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.seconds_count <= SEC_LAST)
		else $error("seconds counter out of range");

	// An empty output register never blocks the input side.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

	// A held beat moves into the output register once the sink has room.
	a_beat_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && m_tready) |=> m_tvalid)
		else $error("buffered beat did not reach the output");

endmodule

`default_nettype wire
